FILE: design/ccre_pkg.sv
// ccre_pkg: shared types and constants of the can command/response engine
// used by the top level, front and back modules, no dependencies of its own
package ccre_pkg;

  localparam int CounterWidthDefault = 32;
  localparam int NumStats = 7;
  localparam logic [15:0] DefaultTimeoutReset = 16'd100;
  localparam logic [3:0] MaxPayload = 4'd6;
  localparam logic [3:0] RxDlcMin = 4'd3;
  localparam logic [3:0] RxDlcMax = 4'd8;
  localparam logic [7:0] FrameBitsBase = 8'd47;
  localparam logic [7:0] SameAsCommand = 8'hFF;
  localparam logic [15:0] ElapsedMax = 16'hFFFF;

  localparam logic [2:0] ST_TX_OK = 3'd0;
  localparam logic [2:0] ST_TX_BITS = 3'd1;
  localparam logic [2:0] ST_RX_BITS = 3'd2;
  localparam logic [2:0] ST_FILTERED = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_CRC_ERROR = 3'd5;
  localparam logic [2:0] ST_RX_OK = 3'd6;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_RX,
    OP_TICK,
    OP_STAT
  } op_t;

  typedef enum logic [2:0] {
    K_SENT,
    K_WAIT,
    K_REPLY,
    K_TIMEOUT,
    K_CRCERR,
    K_LARGE,
    K_BUSY,
    K_STAT
  } kind_t;

  // classified item between front and back
  typedef struct packed {
    op_t         op;
    logic [10:0] can_id;
    logic [7:0]  wanted;
    logic        want;
    logic [15:0] timeout;
    logic [2:0]  stat_select;
    logic        too_large;
    logic [3:0]  dlc;
    logic [63:0] frame;
    logic [7:0]  bits;
    logic        rx_len_ok;
    logic        rx_crc_ok;
    logic [7:0]  rx_cmd;
    logic [2:0]  payload_length;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] frame_id;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_data;
    logic [2:0]  payload_length;
    logic [31:0] stat_value;
  } result_t;

endpackage

FILE: design/can_command_response_engine.sv
// can_command_response_engine: top level, front classifier, item queue,
// back executor and result queue; depends on ccre_pkg, ccre_fifo, ccre_front, ccre_back
//
// One beat is taken per clock and one result per clock leaves in steady state,
// as long as pop keeps the result queue from filling. A beat accepted by push
// sits in the two-entry item queue, is carried out by the back part when the
// two-entry result queue has room, and its result is registered in that queue
// and shows on the result ports from there. Frames and ticks while idle, ticks
// that do not expire and filtered frames give no result. full rises only when
// the result side has stalled long enough to fill both queues.
module can_command_response_engine #(
  parameter int COUNTER_WIDTH = ccre_pkg::CounterWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [10:0] can_id,
  input  logic [7:0]  command,
  input  logic [3:0]  length,
  input  logic [63:0] data,
  input  logic [7:0]  expected_cmd,
  input  logic        reply_needed,
  input  logic [15:0] timeout,
  input  logic [2:0]  stat_select,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [10:0] frame_id,
  output logic [3:0]  frame_dlc,
  output logic [63:0] frame_data,
  output logic [2:0]  payload_length,
  output logic [31:0] stat_value
);
  import ccre_pkg::*;

  item_t   front_item;
  item_t   back_item;
  logic    mid_empty;
  logic    out_full;
  logic    back_go;
  logic    res_valid;
  logic    res_push;
  result_t back_res;
  result_t out_res;

  ccre_front u_front (
    .operation       (operation),
    .can_id          (can_id),
    .command         (command),
    .length          (length),
    .data            (data),
    .expected_cmd    (expected_cmd),
    .reply_needed    (reply_needed),
    .timeout         (timeout),
    .stat_select     (stat_select),
    .item            (front_item)
  );

  ccre_fifo #(.T(item_t)) u_item_q (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .data_in  (front_item),
    .full     (full),
    .pop      (back_go),
    .data_out (back_item),
    .empty    (mid_empty)
  );

  assign back_go = !mid_empty && !out_full;
  assign res_push = back_go && res_valid;

  ccre_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .go        (back_go),
    .item      (back_item),
    .res_valid (res_valid),
    .res       (back_res)
  );

  ccre_fifo #(.T(result_t)) u_result_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .data_in  (back_res),
    .full     (out_full),
    .pop      (pop),
    .data_out (out_res),
    .empty    (empty)
  );

  assign kind = out_res.kind;
  assign frame_id = out_res.frame_id;
  assign frame_dlc = out_res.frame_dlc;
  assign frame_data = out_res.frame_data;
  assign payload_length = out_res.payload_length;
  assign stat_value = out_res.stat_value;

  // sends and statistic reads always produce a result beat
  a_send_stat_result: assert property (@(posedge clk) disable iff (rst)
    (back_go && (back_item.op == OP_SEND || back_item.op == OP_STAT)) |-> res_push)
    else $error("send or statistic beat produced no result");

  // the back part never pushes into a full result queue
  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && !mid_empty |-> (res_push || out_full) && !(res_push && out_full))
    else $error("result pushed into full queue");

  // both queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk)
    rst |=> (!full && empty))
    else $error("queues not drained after reset");

endmodule

FILE: design/ccre_fifo.sv
// ccre_fifo: two-entry queue of any packed type
// used between front and back and on the result side, no package needed
module ccre_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     data_in,
  output logic full,
  input  logic pop,
  output T     data_out,
  output logic empty
);

  T           mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       pop_ok;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

FILE: design/ccre_front.sv
// ccre_front: classifies an input beat, builds the tx frame and checks rx frames
// depends on ccre_pkg
module ccre_front (
  input  logic [1:0]           operation,
  input  logic [10:0]          can_id,
  input  logic [7:0]           command,
  input  logic [3:0]           length,
  input  logic [63:0]          data,
  input  logic [7:0]           expected_cmd,
  input  logic                 reply_needed,
  input  logic [15:0]          timeout,
  input  logic [2:0]           stat_select,
  output ccre_pkg::item_t      item
);
  import ccre_pkg::*;

  logic [7:0]  tx_sum;
  logic [7:0]  rx_sum;
  logic [63:0] tx_frame;
  logic [63:0] rx_payload;
  logic [3:0]  tx_dlc;
  logic [2:0]  len_m1;
  logic        len_ok;
  op_t         op;

  assign op = op_t'(operation);
  assign tx_dlc = length + 4'd2;
  assign len_m1 = 3'(length - 4'd1);
  assign len_ok = (length >= RxDlcMin) && (length <= RxDlcMax);

  // tx frame: command, payload, checksum
  always_comb begin
    tx_sum = can_id[7:0] + command;
    for (int k = 0; k < 6; k++) begin
      if (k < int'(length)) begin
        tx_sum = tx_sum + data[8*k +: 8];
      end
    end
    tx_frame = 64'd0;
    tx_frame[7:0] = command;
    for (int k = 1; k < 8; k++) begin
      if (k <= int'(length)) begin
        tx_frame[8*k +: 8] = data[8*k-8 +: 8];
      end else if (k == int'(length) + 1) begin
        tx_frame[8*k +: 8] = tx_sum;
      end
    end
  end

  // rx frame: checksum over all but the last byte, payload moved down
  always_comb begin
    rx_sum = can_id[7:0];
    for (int k = 0; k < 8; k++) begin
      if (k + 1 < int'(length)) begin
        rx_sum = rx_sum + data[8*k +: 8];
      end
    end
    rx_payload = 64'd0;
    for (int k = 0; k < 7; k++) begin
      if (k + 2 < int'(length)) begin
        rx_payload[8*k +: 8] = data[8*k+8 +: 8];
      end
    end
  end

  always_comb begin
    item.op = op;
    item.can_id = can_id;
    item.wanted = (expected_cmd == SameAsCommand) ? command : expected_cmd;
    item.want = reply_needed;
    item.timeout = timeout;
    item.stat_select = stat_select;
    item.too_large = (length > MaxPayload);
    item.dlc = tx_dlc;
    item.rx_len_ok = len_ok;
    item.rx_crc_ok = (rx_sum == data[8*len_m1 +: 8]);
    item.rx_cmd = data[7:0];
    if (op == OP_SEND) begin
      item.frame = tx_frame;
      item.bits = FrameBitsBase + 8'({tx_dlc, 3'b000});
      item.payload_length = 3'd0;
    end else begin
      item.frame = rx_payload;
      item.bits = FrameBitsBase + 8'({length, 3'b000});
      item.payload_length = len_ok ? 3'(length - 4'd2) : 3'd0;
    end
  end

endmodule

FILE: design/ccre_back.sv
// ccre_back: wait state, timeout, reply matching and statistic counters
// depends on ccre_pkg
module ccre_back #(
  parameter int COUNTER_WIDTH = ccre_pkg::CounterWidthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [15:0]          cfg_data,
  input  logic                 go,
  input  ccre_pkg::item_t      item,
  output logic                 res_valid,
  output ccre_pkg::result_t    res
);
  import ccre_pkg::*;

  logic [15:0]              default_timeout;
  logic                     waiting;
  logic [10:0]              target_id;
  logic [7:0]               wanted_reply;
  logic [15:0]              wait_limit;
  logic [15:0]              elapsed_ms;
  logic [COUNTER_WIDTH-1:0] counters [NumStats];

  logic                     waiting_next;
  logic [15:0]              elapsed_next;
  logic                     load_wait;
  logic [7:0]               bump [NumStats];
  logic [15:0]              elapsed_inc;
  logic                     expired;

  assign elapsed_inc = (elapsed_ms != ElapsedMax) ? elapsed_ms + 16'd1 : elapsed_ms;
  assign expired = (elapsed_ms >= wait_limit);

  always_comb begin
    waiting_next = waiting;
    elapsed_next = elapsed_ms;
    load_wait = 1'b0;
    res_valid = 1'b0;
    res = '0;
    for (int i = 0; i < NumStats; i++) begin
      bump[i] = 8'd0;
    end
    unique case (item.op)
      OP_SEND: begin
        res_valid = 1'b1;
        if (waiting) begin
          res.kind = K_BUSY;
        end else if (item.too_large) begin
          res.kind = K_LARGE;
        end else begin
          bump[ST_TX_OK] = 8'd1;
          bump[ST_TX_BITS] = item.bits;
          res.frame_id = item.can_id;
          res.frame_dlc = item.dlc;
          res.frame_data = item.frame;
          if (!item.want || item.can_id == 11'd0) begin
            res.kind = K_SENT;
          end else begin
            res.kind = K_WAIT;
            waiting_next = 1'b1;
            load_wait = 1'b1;
            elapsed_next = 16'd0;
          end
        end
      end
      OP_RX: begin
        if (waiting) begin
          if (expired) begin
            waiting_next = 1'b0;
            bump[ST_TIMEOUT] = 8'd1;
            res_valid = 1'b1;
            res.kind = K_TIMEOUT;
          end else begin
            bump[ST_RX_BITS] = item.bits;
            if (item.can_id != target_id || !item.rx_len_ok
                || item.rx_cmd != wanted_reply) begin
              bump[ST_FILTERED] = 8'd1;
            end else begin
              waiting_next = 1'b0;
              res_valid = 1'b1;
              if (item.rx_crc_ok) begin
                bump[ST_RX_OK] = 8'd1;
                res.kind = K_REPLY;
                res.frame_data = item.frame;
                res.payload_length = item.payload_length;
              end else begin
                bump[ST_CRC_ERROR] = 8'd1;
                res.kind = K_CRCERR;
              end
            end
          end
        end
      end
      OP_TICK: begin
        if (waiting) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= wait_limit) begin
            waiting_next = 1'b0;
            bump[ST_TIMEOUT] = 8'd1;
            res_valid = 1'b1;
            res.kind = K_TIMEOUT;
          end
        end
      end
      OP_STAT: begin
        res_valid = 1'b1;
        res.kind = K_STAT;
        if (item.stat_select < 3'(NumStats)) begin
          res.stat_value = 32'(counters[item.stat_select]);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= DefaultTimeoutReset;
      waiting <= 1'b0;
      target_id <= 11'd0;
      wanted_reply <= 8'd0;
      wait_limit <= 16'd0;
      elapsed_ms <= 16'd0;
      for (int i = 0; i < NumStats; i++) begin
        counters[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        default_timeout <= cfg_data;
      end
      if (go) begin
        waiting <= waiting_next;
        elapsed_ms <= elapsed_next;
        if (load_wait) begin
          target_id <= item.can_id;
          wanted_reply <= item.wanted;
          wait_limit <= (item.timeout == 16'd0) ? default_timeout : item.timeout;
        end
        for (int i = 0; i < NumStats; i++) begin
          counters[i] <= counters[i] + COUNTER_WIDTH'(bump[i]);
        end
      end
    end
  end

endmodule
